[src/bdlp_pkg.sv]
package bdlp_pkg;

    // Debounce machine phases
    typedef enum logic [2:0] {
        PH_RELEASED = 3'd0,
        PH_FALLING  = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_RISING   = 3'd3,
        PH_LONG     = 3'd4
    } t_phase;

    // Latched event codes, as returned on a read
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_PRESSED   = 3'd1,
        EV_LONG      = 3'd2,
        EV_SHORT_REL = 3'd3,
        EV_LONG_REL  = 3'd4
    } t_event;

    // Request kinds carried in tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE   = 1'b0;
    localparam logic CFG_LONG_PRESS = 1'b1;

    localparam int DEB_W = 8;
    localparam int LONG_W = 16;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 8'd5;
    localparam logic [LONG_W-1:0] LONG_PRESS_RESET = 16'd100;

endpackage

[src/button_debounce_long_press.sv]
// Button debouncer with long-press detection.
// Input stream s_axis: each item is a tick carrying one active-low pin sample
// (tuser = 0, tdata[0] = pin level) or a read of the pending event (tuser = 1).
// Output stream m_axis: exactly one item per input item; tdata[2:0] is the
// event code on a read (0 none, 1 pressed, 2 long press, 3 short release,
// 4 long release) and 0 on a tick.
// Configuration channel: index 0 = debounce ticks (8 bits), index 1 =
// long-press ticks (16 bits); writes complete in the cycle they are offered
// and belong in idle periods only.
// Throughput: one item per cycle while the skid entry is empty; the phase,
// counter and event registers update at acceptance.
// Stall: a two-entry output buffer (result register plus skid register)
// lets one more item in while a result waits; s_axis_tready drops only when
// both entries are full.
// Reset (synchronous, active low): phase released, counters zero, no event
// pending, registers back to 5 and 100, output buffer empty.
module button_debounce_long_press #(
    parameter int HELD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
    input  logic        s_axis_tuser,   // [0] req_type
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [2:0] event_code, [7:3] zero
);
    import bdlp_pkg::*;

    localparam int CMP_W = (HELD_BITS > LONG_W) ? HELD_BITS : LONG_W;

    logic [DEB_W-1:0]     r_deb_ticks;
    logic [LONG_W-1:0]    r_long_ticks;
    t_phase               r_phase, n_phase;
    logic [DEB_W-1:0]     r_deb_cnt, n_deb_cnt;
    logic [HELD_BITS-1:0] r_held, n_held;
    t_event               r_pend, n_pend;

    logic                 r_out_valid, r_skid_valid;
    t_event               r_out_code, r_skid_code;

    logic                 accept, take, is_tick, pressed;
    logic [DEB_W-1:0]     deb_inc;
    logic [HELD_BITS-1:0] held_inc;
    logic                 deb_done, long_now, long_inc;
    t_event               res_code;

    // Handshakes
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = r_out_valid && m_axis_tready;
    assign is_tick       = accept && (s_axis_tuser == REQ_TICK);
    assign pressed       = !s_axis_tdata[0];

    // Saturating increments and threshold compares
    assign deb_inc  = (&r_deb_cnt) ? r_deb_cnt : r_deb_cnt + 1'b1;
    assign held_inc = (&r_held) ? r_held : r_held + 1'b1;
    assign deb_done = deb_inc >= r_deb_ticks;
    assign long_now = CMP_W'(r_held) >= CMP_W'(r_long_ticks);
    assign long_inc = CMP_W'(held_inc) >= CMP_W'(r_long_ticks);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (is_tick) begin
            case (r_phase)
                PH_FALLING: begin
                    if (!pressed) n_phase = PH_RELEASED;
                    else if (deb_done) n_phase = PH_PRESSED;
                end
                PH_PRESSED: begin
                    if (!pressed) n_phase = PH_RISING;
                    else if (long_inc) n_phase = PH_LONG;
                end
                PH_RISING: begin
                    if (pressed) n_phase = long_now ? PH_LONG : PH_PRESSED;
                    else if (deb_done) n_phase = PH_RELEASED;
                end
                PH_LONG: begin
                    if (!pressed) n_phase = PH_RISING;
                end
                default: begin
                    n_phase = pressed ? PH_FALLING : PH_RELEASED;
                end
            endcase
        end
    end

    // Counters, pending event and result code
    always_comb begin
        n_deb_cnt = r_deb_cnt;
        n_held    = r_held;
        n_pend    = r_pend;
        res_code  = EV_NONE;
        if (accept && (s_axis_tuser == REQ_READ)) begin
            res_code = r_pend;
            n_pend   = EV_NONE;
        end else if (is_tick) begin
            case (r_phase)
                PH_FALLING: begin
                    if (pressed) begin
                        n_deb_cnt = deb_inc;
                        if (deb_done) begin
                            n_pend = EV_PRESSED;
                            n_held = '0;
                        end
                    end
                end
                PH_PRESSED: begin
                    if (pressed) begin
                        n_held = held_inc;
                        if (long_inc) n_pend = EV_LONG;
                    end else begin
                        n_deb_cnt = '0;
                    end
                end
                PH_RISING: begin
                    if (!pressed) begin
                        n_deb_cnt = deb_inc;
                        if (deb_done) begin
                            n_pend = long_now ? EV_LONG_REL : EV_SHORT_REL;
                            n_held = '0;
                        end
                    end
                end
                PH_LONG: begin
                    if (pressed) n_held = held_inc;
                    else n_deb_cnt = '0;
                end
                default: begin
                    if (pressed) n_deb_cnt = '0;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_ticks  <= DEBOUNCE_RESET;
            r_long_ticks <= LONG_PRESS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:   r_deb_ticks  <= i_cfg_data[DEB_W-1:0];
                CFG_LONG_PRESS: r_long_ticks <= i_cfg_data;
                default:        r_deb_ticks  <= r_deb_ticks;
            endcase
        end
    end

    // Machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RELEASED;
            r_deb_cnt <= '0;
            r_held    <= '0;
            r_pend    <= EV_NONE;
        end else begin
            r_phase   <= n_phase;
            r_deb_cnt <= n_deb_cnt;
            r_held    <= n_held;
            r_pend    <= n_pend;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Result payload: refill from skid first, else take the new item
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out_code <= r_skid_valid ? r_skid_code : res_code;
        end else if (accept) begin
            r_skid_code <= res_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_code};

endmodule

[dv/button_debounce_long_press_test.sv]
module button_debounce_long_press_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bdlp_pkg::*;

    localparam int HELD_W = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] pin_level, [7:1] zero
    logic        s_axis_tuser;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [2:0] event_code, [7:3] zero

    button_debounce_long_press #(
        .HELD_BITS(HELD_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Debouncer state as the testbench sees it
    t_phase              button_phase = PH_RELEASED;
    logic [DEB_W-1:0]    deb_count    = '0;
    logic [HELD_W-1:0]   held_ticks   = '0;
    t_event              pending_ev   = EV_NONE;
    logic [DEB_W-1:0]    deb_limit    = DEBOUNCE_RESET;
    logic [LONG_W-1:0]   long_limit   = LONG_PRESS_RESET;

    // Event codes still owed by the block, oldest first
    t_event events_due[$];

    bit snd_idle;
    bit rcv_idle;
    int hold_off_len;
    int items_in;
    int results_seen;
    int cfg_writes;
    int fail_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Advance the debouncer by one item and return the event code it reads out
    function automatic t_event next_event(logic req, logic pin);
        t_event ev;
        logic   down;
        ev = EV_NONE;
        down = (pin == 1'b0);
        if (req == REQ_READ) begin
            ev = pending_ev;
            pending_ev = EV_NONE;
        end else begin
            case (button_phase)
                PH_FALLING: begin
                    if (down) begin
                        if (deb_count != '1) deb_count++;
                        if (deb_count >= deb_limit) begin
                            button_phase = PH_PRESSED;
                            pending_ev = EV_PRESSED;
                            held_ticks = '0;
                        end
                    end else begin
                        button_phase = PH_RELEASED;
                    end
                end
                PH_PRESSED: begin
                    if (down) begin
                        if (held_ticks != '1) held_ticks++;
                        if (held_ticks >= long_limit) begin
                            button_phase = PH_LONG;
                            pending_ev = EV_LONG;
                        end
                    end else begin
                        button_phase = PH_RISING;
                        deb_count = '0;
                    end
                end
                PH_RISING: begin
                    if (!down) begin
                        if (deb_count != '1) deb_count++;
                        if (deb_count >= deb_limit) begin
                            pending_ev = (held_ticks >= long_limit) ? EV_LONG_REL : EV_SHORT_REL;
                            button_phase = PH_RELEASED;
                            held_ticks = '0;
                        end
                    end else begin
                        // bounce on release: fall back to the held phase
                        button_phase = (held_ticks >= long_limit) ? PH_LONG : PH_PRESSED;
                    end
                end
                PH_LONG: begin
                    if (down) begin
                        if (held_ticks != '1) held_ticks++;
                    end else begin
                        button_phase = PH_RISING;
                        deb_count = '0;
                    end
                end
                default: begin
                    button_phase = down ? PH_FALLING : PH_RELEASED;
                    if (down) deb_count = '0;
                end
            endcase
        end
        return ev;
    endfunction

    // Offer one item, after a random gap when snd_idle is set, and record what it should produce
    task automatic send_item(logic req, logic pin);
        int gap;
        gap = snd_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'b0, pin};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        events_due.push_back(next_event(req, pin));
        items_in++;
        @(negedge i_clk);
    endtask

    task automatic hold_pin(logic pin, int n);
        repeat (n) send_item(REQ_TICK, pin);
    endtask

    // Read with a random pin value, which the block must ignore
    task automatic read_event();
        send_item(REQ_READ, 1'($urandom_range(0, 1)));
    endtask

    task automatic maybe_read();
        if ($urandom_range(0, 9) < 4) read_event();
    endtask

    // Drop valid and wait until every result is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (events_due.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Write both limits back to back; call only when the block is idle
    task automatic write_settings(logic [15:0] deb, logic [15:0] lp);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_DEBOUNCE;
        i_cfg_data  <= deb;
        do @(posedge i_clk); while (!o_cfg_ready);
        deb_limit = deb[DEB_W-1:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_LONG_PRESS;
        i_cfg_data  <= lp;
        do @(posedge i_clk); while (!o_cfg_ready);
        long_limit = lp;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // Reset limits: empty reads, a clean press, bounces on both edges
    task automatic test_reset_limits();
        snd_idle = 1'b1;
        rcv_idle = 1'b1;
        read_event();
        send_item(REQ_READ, 1'b0);
        send_item(REQ_READ, 1'b1);
        hold_pin(1'b0, 7);
        read_event();
        hold_pin(1'b1, 3);
        hold_pin(1'b0, 2);
        hold_pin(1'b1, 7);
        read_event();
        hold_pin(1'b0, 3);
        hold_pin(1'b1, 1);
        read_event();
    endtask

    // Zero limits: every confirming tick accepts, every hold is long
    task automatic test_zero_limits();
        settle();
        write_settings(16'd0, 16'd0);
        hold_pin(1'b0, 3);
        read_event();
        hold_pin(1'b1, 1);
        hold_pin(1'b0, 1);
        hold_pin(1'b1, 2);
        read_event();
    endtask

    // Release just below and exactly at the long-press limit
    task automatic test_release_threshold();
        settle();
        write_settings(16'd1, 16'd3);
        hold_pin(1'b0, 4);
        hold_pin(1'b1, 2);
        read_event();
        hold_pin(1'b0, 5);
        read_event();
        hold_pin(1'b1, 2);
        read_event();
    endtask

    // Full-scale limits: the debounce write truncates to 255 and the
    // long-press limit of 65535 is never reached, so the release is short
    task automatic test_full_scale();
        settle();
        snd_idle = 1'b0;
        rcv_idle = 1'b0;
        write_settings(16'hFFFF, 16'hFFFF);
        hold_pin(1'b0, 257);
        hold_pin(1'b0, 4);
        read_event();
        settle();
        write_settings(16'd1, 16'hFFFF);
        hold_pin(1'b1, 3);
        read_event();
    endtask

    // Receiver holds off while items keep coming, so the input stalls
    task automatic test_output_stall();
        settle();
        write_settings(16'd2, 16'd4);
        snd_idle = 1'b0;
        hold_off_len = 40;
        repeat (30) send_item(1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
    endtask

    // One press cycle with random timing and bounces, or a burst of noise
    task automatic press_episode(int deb, int lp);
        if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 6))
                send_item(1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            hold_pin(1'b0, $urandom_range(1, deb + 1));
            hold_pin(1'b1, 1);
        end
        hold_pin(1'b0, deb + 2 + $urandom_range(0, 1));
        maybe_read();
        hold_pin(1'b0, $urandom_range(0, lp + 8));
        if ($urandom_range(0, 2) == 0) begin
            hold_pin(1'b1, 1 + $urandom_range(0, deb));
            hold_pin(1'b0, $urandom_range(1, 6));
        end
        maybe_read();
        hold_pin(1'b1, deb + 2 + $urandom_range(0, 2));
        maybe_read();
    endtask

    // Random sessions, each with its own limits and idling mix
    task automatic test_random_sessions();
        int deb;
        int lp;
        int start;
        for (int s = 0; s < 4; s++) begin
            settle();
            deb = $urandom_range(0, 6);
            lp  = $urandom_range(0, 24);
            write_settings(16'(deb), 16'(lp));
            snd_idle = s[0];
            rcv_idle = s[1];
            start = items_in;
            while (items_in - start < 40) press_episode(deb, lp);
        end
    endtask

    // Result receiver: random stalls plus one long hold-off on request
    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = rcv_idle ? $urandom_range(0, 16) : 0;
            if (hold_off_len > 0) begin
                stall = hold_off_len;
                hold_off_len = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Compare each accepted result with the oldest owed event
    always @(posedge i_clk) begin : result_check
        t_event want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (events_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result %0d arrived with nothing owed, tdata %0h",
                             results_seen, m_axis_tdata);
            end else begin
                want = events_due.pop_front();
                if (m_axis_tdata !== {5'b0, want}) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d: expected event %0d, got tdata %0h",
                                 results_seen, want, m_axis_tdata);
                end
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_DEBOUNCE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_TICK;
        snd_idle      = 1'b0;
        rcv_idle      = 1'b0;
        hold_off_len  = 0;
        items_in      = 0;
        results_seen  = 0;
        cfg_writes    = 0;
        fail_count    = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_limits();
        test_zero_limits();
        test_release_threshold();
        test_full_scale();
        test_output_stall();
        test_random_sessions();

        // Drain with a bound; anything still owed counts against the run
        s_axis_tvalid <= 1'b0;
        for (int w = 0; w < 200 && events_due.size() != 0; w++) @(negedge i_clk);
        if (events_due.size() != 0) begin
            $display("%0d results never arrived", events_due.size());
            fail_count += events_due.size();
        end
        repeat (4) @(negedge i_clk);

        $display("Run sent %0d items, checked %0d results, made %0d register writes,",
                 items_in, results_seen, cfg_writes);
        $display("with zero and full-scale limits, bounces on both edges and output stalls.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
src/bdlp_pkg.sv
src/button_debounce_long_press.sv
dv/button_debounce_long_press_test.sv
